/* design/vec_pkg.sv */
`default_nettype none

package vec_pkg;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DvdW  = 27;
  localparam int unsigned DvsW  = 16;
  localparam int unsigned QuotW = 12;

  localparam logic [2:0] ActRefused   = 3'd0;
  localparam logic [2:0] ActIdle      = 3'd1;
  localparam logic [2:0] ActWaiting   = 3'd2;
  localparam logic [2:0] ActMove      = 3'd3;
  localparam logic [2:0] ActMoveDone  = 3'd4;
  localparam logic [2:0] ActConverged = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgGimbalReady   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAngleMin      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAngleMax      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStepLimit     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMoveSpeed     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgConvergePix   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxMoves      = 3'd6;

  typedef struct packed {
    logic             start;
    logic [DvdW-1:0]  dividend;
    logic [DvsW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [12:0] clamp_angle(input logic signed [13:0] a,
                                                     input logic signed [12:0] lo,
                                                     input logic signed [12:0] hi);
    logic signed [13:0] lo_x;
    logic signed [13:0] hi_x;
    lo_x = 14'(lo);
    hi_x = 14'(hi);
    if (a < lo_x) begin
      return lo;
    end else if (a > hi_x) begin
      return hi;
    end
    return 13'(a);
  endfunction

endpackage

`default_nettype wire

/* design/vec_div.sv */
`default_nettype none

module vec_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vec_pkg::div_req_t  req_i,
  output logic               busy_o,
  output vec_pkg::div_rsp_t  rsp_o
);
  import vec_pkg::*;

  logic [DvsW-1:0]  rem_q;
  logic [QuotW-1:0] low_q;
  logic [3:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DvsW:0]    trial;
  logic             qbit;

  assign trial = {rem_q, low_q[QuotW-1]};
  assign qbit  = (trial >= {1'b0, req_i.divisor});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.dividend[DvdW-1:QuotW]};
      low_q <= req_i.dividend[QuotW-1:0];
    end else if (busy_q) begin
      rem_q <= qbit ? DvsW'(trial - {1'b0, req_i.divisor}) : trial[DvsW-1:0];
      low_q <= {low_q[QuotW-2:0], qbit};
    end
  end

  assign busy_o     = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 4'd0) else $error("divider busy with empty count");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 4'd1 && !req_i.start) |=> done_q) else $error("divider lost done");

endmodule

`default_nettype wire

/* design/vision_error_correction_step.sv */
// Vision error correction step for a two-axis gimbal.
// Input stream: s_axis_tuser selects a start request (0) or a camera report (1);
// s_axis_tdata carries the lost flag, pixel errors and current yaw/pitch.
// Output stream: one result per request; m_axis_tuser is the action code and
// m_axis_tdata the clamped yaw/pitch targets and axis speeds (zero when no move).
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only
// while idle; the block itself does not enforce this. A refused, idle or waiting
// result goes from the accept state straight to the output state, a converged one
// through the sum state first. A move runs the sequencer over four multiply/divide
// passes on one shared 12-step restoring divider, fewer passes when an error or a
// step is zero, and s_axis_tready stays low until the result reaches the output
// register. The sequencer takes a new request only once it is back in idle.
// The result sits in an output register; a new request is taken while it waits.
// When the receiver stalls, the next result is held in the sequencer until the
// output register frees, and no further request is taken.
// Reset clears the session, move count, stored report and restores register
// defaults; no result is pending afterwards.
`default_nettype none

module vision_error_correction_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vision_lost, err_x, err_y, yaw_now, pitch_now
  input  logic [vec_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // yaw_target, pitch_target, yaw_rpm, pitch_rpm
  output logic [vec_pkg::OutDataW-1:0]  m_axis_tdata,
  // action
  output logic [2:0]                    m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [vec_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vec_pkg::CfgDataW-1:0]  cfg_data_i
);
  import vec_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StDivGo = 3'd3;
  localparam logic [2:0] StDivW  = 3'd4;
  localparam logic [2:0] StClamp = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] st_q, st_d;

  logic               cfg_ready_q;
  logic signed [12:0] amin_q, amax_q;
  logic [11:0]        slim_q, mspd_q;
  logic [15:0]        conv_q;
  logic [7:0]         maxmv_q;

  logic               session_q;
  logic [7:0]         moves_q;
  logic [15:0]        last_x_q, last_y_q;
  logic               last_ok_q;
  logic signed [12:0] yaw_q, pitch_q;
  logic [15:0]        vmax_q;
  logic [1:0]         phase_q;
  logic [DvdW-1:0]    prod_q;
  logic [11:0]        dy_mag_q, dp_mag_q;

  logic [2:0]         res_act_q;
  logic signed [12:0] res_yaw_q, res_pitch_q;
  logic [11:0]        res_ys_q, res_ps_q;

  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [2:0]         out_user_q;

  logic               in_kind, in_lost;
  logic [15:0]        in_x, in_y;
  logic signed [12:0] in_yaw, in_pitch;
  logic               accept, go_proc, out_free;

  logic [15:0]        ax, ay, vmax;
  logic [16:0]        err_sum;
  logic               conv_hit, vmax_zero;
  logic [11:0]        smax;
  logic               smax_zero;
  logic [15:0]        mul_a;
  logic [11:0]        mul_b;
  logic [27:0]        mul_p;
  logic [11:0]        quot_fix;
  logic signed [12:0] dy_s, dp_s;
  logic signed [13:0] yaw_sum, pitch_sum;
  logic [7:0]         moves_inc;
  logic               fin;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               div_busy;

  assign in_kind  = s_axis_tuser;
  assign in_lost  = s_axis_tdata[0];
  assign in_x     = s_axis_tdata[16:1];
  assign in_y     = s_axis_tdata[32:17];
  assign in_yaw   = s_axis_tdata[45:33];
  assign in_pitch = s_axis_tdata[58:46];

  assign s_axis_tready = (st_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign go_proc       = in_kind ? (session_q && !in_lost) : (cfg_ready_q && last_ok_q);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign ax        = last_x_q[15] ? (~last_x_q + 16'd1) : last_x_q;
  assign ay        = last_y_q[15] ? (~last_y_q + 16'd1) : last_y_q;
  assign err_sum   = {1'b0, ax} + {1'b0, ay};
  assign conv_hit  = err_sum < {1'b0, conv_q};
  assign vmax      = (ax >= ay) ? ax : ay;
  assign vmax_zero = (vmax == 16'd0);
  assign smax      = (dy_mag_q >= dp_mag_q) ? dy_mag_q : dp_mag_q;
  assign smax_zero = (smax == 12'd0);

  always_comb begin
    unique case (phase_q)
      2'd0:    mul_a = ax;
      2'd1:    mul_a = ay;
      2'd2:    mul_a = {4'd0, dy_mag_q};
      default: mul_a = {4'd0, dp_mag_q};
    endcase
  end
  assign mul_b = phase_q[1] ? mspd_q : slim_q;
  assign mul_p = 28'(mul_a) * 28'(mul_b);

  assign div_req.start    = (st_q == StDivGo);
  assign div_req.dividend = phase_q[1] ? (prod_q + DvdW'(smax) - DvdW'(1))
                                       : (prod_q + DvdW'(vmax_q[15:1]));
  assign div_req.divisor  = phase_q[1] ? DvsW'(smax) : vmax_q;
  assign quot_fix         = (div_rsp.quot == 12'd0) ? 12'd1 : div_rsp.quot;

  vec_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .rsp_o  (div_rsp)
  );

  assign dy_s      = last_x_q[15] ? (~{1'b0, dy_mag_q} + 13'd1) : {1'b0, dy_mag_q};
  assign dp_s      = last_y_q[15] ? (~{1'b0, dp_mag_q} + 13'd1) : {1'b0, dp_mag_q};
  assign yaw_sum   = 14'(yaw_q) + 14'(dy_s);
  assign pitch_sum = 14'(pitch_q) + 14'(dp_s);
  assign moves_inc = moves_q + 8'd1;
  assign fin       = (moves_inc >= maxmv_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (accept) st_d = go_proc ? StSum : StOut;
      StSum: begin
        if (conv_hit) begin
          st_d = StOut;
        end else if (vmax_zero) begin
          st_d = StClamp;
        end else begin
          st_d = StMul;
        end
      end
      StMul:   st_d = (phase_q[1] && smax_zero) ? StClamp : StDivGo;
      StDivGo: st_d = StDivW;
      StDivW:  if (div_rsp.done) st_d = (phase_q == 2'd3) ? StClamp : StMul;
      StClamp: st_d = StOut;
      StOut:   if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      cfg_ready_q <= 1'b0;
      amin_q      <= -13'sd900;
      amax_q      <= 13'sd900;
      slim_q      <= 12'd50;
      mspd_q      <= 12'd60;
      conv_q      <= 16'd5;
      maxmv_q     <= 8'd10;
      session_q   <= 1'b0;
      moves_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_ok_q   <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgGimbalReady: cfg_ready_q <= cfg_data_i[0];
          CfgAngleMin:    amin_q      <= cfg_data_i[12:0];
          CfgAngleMax:    amax_q      <= cfg_data_i[12:0];
          CfgStepLimit:   slim_q      <= cfg_data_i[11:0];
          CfgMoveSpeed:   mspd_q      <= cfg_data_i[11:0];
          CfgConvergePix: conv_q      <= cfg_data_i;
          CfgMaxMoves:    maxmv_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (st_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (accept) begin
            if (!in_kind) begin
              if (cfg_ready_q) begin
                session_q <= 1'b1;
                moves_q   <= '0;
              end
            end else begin
              last_x_q  <= in_x;
              last_y_q  <= in_y;
              last_ok_q <= !in_lost;
            end
          end
        end
        StSum: begin
          if (conv_hit) begin
            session_q <= 1'b0;
          end
          phase_q <= '0;
        end
        StDivW: begin
          if (div_rsp.done) begin
            phase_q <= phase_q + 2'd1;
          end
        end
        StClamp: begin
          moves_q <= moves_inc;
          if (fin) begin
            session_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          yaw_q       <= in_yaw;
          pitch_q     <= in_pitch;
          res_yaw_q   <= '0;
          res_pitch_q <= '0;
          res_ys_q    <= '0;
          res_ps_q    <= '0;
          if (!in_kind) begin
            res_act_q <= cfg_ready_q ? ActWaiting : ActRefused;
          end else begin
            res_act_q <= !session_q ? ActIdle : ActWaiting;
          end
        end
      end
      StSum: begin
        if (conv_hit) begin
          res_act_q <= ActConverged;
        end else if (vmax_zero) begin
          dy_mag_q <= '0;
          dp_mag_q <= '0;
          res_ys_q <= 12'd1;
          res_ps_q <= 12'd1;
        end else begin
          vmax_q <= vmax;
        end
      end
      StMul: begin
        if (phase_q[1] && smax_zero) begin
          res_ys_q <= 12'd1;
          res_ps_q <= 12'd1;
        end else begin
          prod_q <= mul_p[DvdW-1:0];
        end
      end
      StDivW: begin
        if (div_rsp.done) begin
          unique case (phase_q)
            2'd0:    dy_mag_q <= div_rsp.quot;
            2'd1:    dp_mag_q <= div_rsp.quot;
            2'd2:    res_ys_q <= quot_fix;
            default: res_ps_q <= quot_fix;
          endcase
        end
      end
      StClamp: begin
        res_yaw_q   <= clamp_angle(yaw_sum, amin_q, amax_q);
        res_pitch_q <= clamp_angle(pitch_sum, amin_q, amax_q);
        res_act_q   <= fin ? ActMoveDone : ActMove;
      end
      StOut: begin
        if (out_free) begin
          out_data_q <= {6'd0, res_ps_q, res_ys_q, res_pitch_q, res_yaw_q};
          out_user_q <= res_act_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_move_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_user_q == ActMove || out_user_q == ActMoveDone))
      |-> (out_data_q[37:26] != 12'd0 && out_data_q[49:38] != 12'd0))
    else $error("move result with zero speed");
  a_nomove_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_user_q != ActMove && out_user_q != ActMoveDone)
      |-> out_data_q == '0)
    else $error("non-move result with payload");
  a_fin_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClamp && fin) |=> !session_q)
    else $error("session still active after last move");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

/* tb/vision_error_correction_step_checker.sv */
module vision_error_correction_step_checker
  import vec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  // vision_lost, err_x, err_y, yaw_now, pitch_now
  input  logic [InDataW-1:0]   req_data_i,
  // kind
  input  logic                 req_kind_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  // yaw_target, pitch_target, yaw_rpm, pitch_rpm
  input  logic [OutDataW-1:0]  rsp_data_i,
  // action
  input  logic [2:0]           rsp_action_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   mismatches_o,
  output int                   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [12:0] yaw_target;
    logic signed [12:0] pitch_target;
    logic [11:0]        yaw_rpm;
    logic [11:0]        pitch_rpm;
  } correction_t;

  logic               gimbal_ready;
  logic signed [12:0] angle_lo;
  logic signed [12:0] angle_hi;
  logic [11:0]        step_limit;
  logic [11:0]        move_speed;
  logic [15:0]        converge_pixels;
  logic [7:0]         max_moves;

  logic               session_active;
  logic [7:0]         moves_done;
  logic signed [15:0] stored_x;
  logic signed [15:0] stored_y;
  logic               stored_usable;

  correction_t pending_corrections[$];
  correction_t got;
  correction_t want;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint scale_step(input longint comp, input longint vmax);
    longint num;
    num = comp * longint'(step_limit);
    if (num > 0) begin
      num = num + vmax / 2;
    end else if (num < 0) begin
      num = num - vmax / 2;
    end
    return num / vmax;
  endfunction

  function automatic longint axis_speed(input longint step, input longint smax);
    longint s;
    if (step == 0 || smax == 0) begin
      return 1;
    end
    s = (longint'(move_speed) * magnitude(step) + smax - 1) / smax;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic logic signed [12:0] limit_angle(input longint a);
    if (a < longint'(angle_lo)) begin
      return angle_lo;
    end else if (a > longint'(angle_hi)) begin
      return angle_hi;
    end
    return 13'(a);
  endfunction

  function automatic correction_t plan_move(input longint x, input longint y,
                                            input longint yaw, input longint pitch);
    correction_t r;
    longint ax, ay, vmax, dy, dp, smax;
    r = '0;
    ax = magnitude(x);
    ay = magnitude(y);
    vmax = (ax > ay) ? ax : ay;
    dy = 0;
    dp = 0;
    r.yaw_rpm = 12'd1;
    r.pitch_rpm = 12'd1;
    if (ax + ay < longint'(converge_pixels)) begin
      session_active = 1'b0;
      r = '0;
      r.action = ActConverged;
      return r;
    end
    if (vmax != 0) begin
      dy = scale_step(x, vmax);
      dp = scale_step(y, vmax);
      smax = (magnitude(dy) > magnitude(dp)) ? magnitude(dy) : magnitude(dp);
      r.yaw_rpm = 12'(axis_speed(dy, smax));
      r.pitch_rpm = 12'(axis_speed(dp, smax));
    end
    r.yaw_target = limit_angle(yaw + dy);
    r.pitch_target = limit_angle(pitch + dp);
    moves_done = moves_done + 8'd1;
    if (moves_done >= max_moves) begin
      session_active = 1'b0;
      r.action = ActMoveDone;
    end else begin
      r.action = ActMove;
    end
    return r;
  endfunction

  function automatic correction_t predict_correction(input logic is_report,
                                                     input logic [InDataW-1:0] d);
    correction_t r;
    logic signed [12:0] yaw, pitch;
    r = '0;
    yaw = d[45:33];
    pitch = d[58:46];
    if (!is_report) begin
      if (!gimbal_ready) begin
        r.action = ActRefused;
        return r;
      end
      session_active = 1'b1;
      moves_done = 8'd0;
      if (stored_usable) begin
        r = plan_move(stored_x, stored_y, yaw, pitch);
      end else begin
        r.action = ActWaiting;
      end
      return r;
    end
    stored_x = d[16:1];
    stored_y = d[32:17];
    stored_usable = !d[0];
    if (!session_active) begin
      r.action = ActIdle;
    end else if (!stored_usable) begin
      r.action = ActWaiting;
    end else begin
      r = plan_move(stored_x, stored_y, yaw, pitch);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gimbal_ready = 1'b0;
      angle_lo = -13'sd900;
      angle_hi = 13'sd900;
      step_limit = 12'd50;
      move_speed = 12'd60;
      converge_pixels = 16'd5;
      max_moves = 8'd10;
      session_active = 1'b0;
      moves_done = 8'd0;
      stored_x = '0;
      stored_y = '0;
      stored_usable = 1'b0;
      pending_corrections.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGimbalReady: gimbal_ready = cfg_data_i[0];
          CfgAngleMin:    angle_lo = cfg_data_i[12:0];
          CfgAngleMax:    angle_hi = cfg_data_i[12:0];
          CfgStepLimit:   step_limit = cfg_data_i[11:0];
          CfgMoveSpeed:   move_speed = cfg_data_i[11:0];
          CfgConvergePix: converge_pixels = cfg_data_i;
          CfgMaxMoves:    max_moves = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = {rsp_action_i, rsp_data_i[12:0], rsp_data_i[25:13],
               rsp_data_i[37:26], rsp_data_i[49:38]};
        if (pending_corrections.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("%0t: result with no request waiting: action %0d", $realtime,
                     got.action);
          end
        end else begin
          want = pending_corrections.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t: mismatch: expected action %0d yaw %0d pitch %0d speed %0d/%0d",
                       $realtime, want.action, want.yaw_target, want.pitch_target,
                       want.yaw_rpm, want.pitch_rpm);
              $display("%0t:           actual action %0d yaw %0d pitch %0d speed %0d/%0d",
                       $realtime, got.action, got.yaw_target, got.pitch_target,
                       got.yaw_rpm, got.pitch_rpm);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        pending_corrections.push_back(predict_correction(req_kind_i, req_data_i));
      end
      outstanding_o = pending_corrections.size();
    end
  end

endmodule

/* tb/vision_error_correction_step_tb.sv */
module vision_error_correction_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vec_pkg::*;

  localparam logic KindStart  = 1'b0;
  localparam logic KindReport = 1'b1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CfgDataW-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int stall_left = 0;
  logic steady = 1'b0;

  always #4 clk_i = ~clk_i;

  vision_error_correction_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  vision_error_correction_step_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_kind_i    (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .rsp_action_i  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  function automatic int idle_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] rand_err();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'(int'($urandom_range(0, 60)) - 30);
      4, 5, 6:    return 16'(int'($urandom_range(0, 6000)) - 3000);
      7, 8:       return 16'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [12:0] rand_angle();
    case ($urandom_range(0, 19))
      0:       return -13'sd3600;
      1:       return 13'sd3600;
      2:       return 13'sd0;
      default: return 13'(int'($urandom_range(0, 7200)) - 3600);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
        stall_left <= gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic kind, input logic lost,
                              input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [12:0] yaw,
                              input logic signed [12:0] pitch);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {5'd0, pitch, yaw, y, x, lost};
    s_axis_tuser = kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_setup();
    int lo, hi;
    case ($urandom_range(0, 5))
      0: begin
        lo = -3600;
        hi = 3600;
      end
      1: begin
        lo = $urandom_range(1, 3600);
        hi = -int'($urandom_range(0, 3600));
      end
      2: begin
        lo = int'($urandom_range(0, 7200)) - 3600;
        hi = lo;
      end
      default: begin
        lo = -int'($urandom_range(0, 3600));
        hi = $urandom_range(0, 3600);
      end
    endcase
    write_reg(CfgGimbalReady, 16'($urandom_range(0, 7) != 0));
    write_reg(CfgAngleMin, 16'(lo));
    write_reg(CfgAngleMax, 16'(hi));
    case ($urandom_range(0, 5))
      0:       write_reg(CfgStepLimit, 16'd0);
      1:       write_reg(CfgStepLimit, 16'd1);
      2:       write_reg(CfgStepLimit, 16'd3600);
      default: write_reg(CfgStepLimit, 16'($urandom_range(1, 400)));
    endcase
    case ($urandom_range(0, 3))
      0:       write_reg(CfgMoveSpeed, 16'd1);
      1:       write_reg(CfgMoveSpeed, 16'd3000);
      default: write_reg(CfgMoveSpeed, 16'($urandom_range(1, 3000)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(CfgConvergePix, 16'd0);
      1:       write_reg(CfgConvergePix, 16'hffff);
      2:       write_reg(CfgConvergePix, 16'($urandom()));
      default: write_reg(CfgConvergePix, 16'($urandom_range(0, 60)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(CfgMaxMoves, 16'd0);
      1:       write_reg(CfgMaxMoves, 16'd255);
      2:       write_reg(CfgMaxMoves, 16'd1);
      default: write_reg(CfgMaxMoves, 16'($urandom_range(2, 12)));
    endcase
  endtask

  initial begin
    #20ms;
    $display("vision_error_correction_step verification failed");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KindStart;
    cfg_we = 1'b0;
    cfg_idx = CfgGimbalReady;
    cfg_data = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers: gimbal not ready
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, -16'sd32768, 16'sd32767, 13'sd3600, -13'sd3600);
    send_request(KindReport, 1'b1, 16'sd32767, -16'sd32768, -13'sd3600, 13'sd3600);
    drain();
    write_reg(CfgGimbalReady, 16'd1);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, -16'sd32768, 16'sd32767, 13'sd3600, -13'sd3600);
    send_request(KindReport, 1'b0, 16'sd32767, -16'sd32768, -13'sd3600, 13'sd3600);
    send_request(KindReport, 1'b0, 16'sd3, 16'sd1, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b1, 16'sd10, 16'sd10, 13'sd0, 13'sd0);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, 16'sd100, -16'sd7, 13'sd850, -13'sd890);
    send_request(KindStart, 1'b1, 16'sd5, 16'sd5, -13'sd20, 13'sd40);
    send_request(KindReport, 1'b0, -16'sd1, 16'sd0, 13'sd0, 13'sd0);
    drain();
    // zero step, zero threshold, crossed limits, finish on first move
    write_reg(CfgConvergePix, 16'd0);
    write_reg(CfgStepLimit, 16'd0);
    write_reg(CfgMaxMoves, 16'd0);
    write_reg(CfgAngleMin, 16'(100));
    write_reg(CfgAngleMax, 16'(-100));
    write_reg(CfgMoveSpeed, 16'd3000);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd500, -13'sd500);
    send_request(KindReport, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, -13'sd500, 13'sd0);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, 16'sd500, 16'sd200, 13'sd50, 13'sd50);
    drain();
    write_reg(CfgStepLimit, 16'd3600);
    write_reg(CfgMoveSpeed, 16'd1);
    write_reg(CfgConvergePix, 16'hffff);
    write_reg(CfgMaxMoves, 16'd255);
    write_reg(CfgAngleMin, 16'(-3600));
    write_reg(CfgAngleMax, 16'(3600));
    send_request(KindReport, 1'b0, 16'sd32767, 16'sd32767, 13'sd0, 13'sd0);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindStart, 1'b0, 16'sd0, 16'sd0, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, -16'sd32768, -16'sd32768, 13'sd0, 13'sd0);
    send_request(KindReport, 1'b0, 16'sd1, -16'sd32768, 13'sd3600, 13'sd3600);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      random_setup();
      sent = 0;
      while (sent < 325) begin
        steady = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) != 0) begin
          send_request(KindStart, 1'($urandom_range(0, 1)), rand_err(), rand_err(),
                       rand_angle(), rand_angle());
        end else begin
          send_request(KindReport, 1'b1, rand_err(), rand_err(), rand_angle(), rand_angle());
        end
        sent++;
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if ($urandom_range(0, 19) == 0) begin
            send_request(KindStart, 1'($urandom_range(0, 1)), rand_err(), rand_err(),
                         rand_angle(), rand_angle());
          end else begin
            send_request(KindReport, ($urandom_range(0, 9) == 0), rand_err(), rand_err(),
                         rand_angle(), rand_angle());
          end
          sent++;
        end
      end
      steady = 1'b0;
    end

    drain();
    repeat (80) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("vision_error_correction_step verification clean");
    end else begin
      $display("vision_error_correction_step verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/vec_pkg.sv
design/vec_div.sv
design/vision_error_correction_step.sv
tb/vision_error_correction_step_checker.sv
tb/vision_error_correction_step_tb.sv
